>>> rtl/core/tksl_pkg.sv
// Shared constants for the two-key successor lookup block.
package tksl_pkg;

  // Field widths
  localparam int PORT_W  = 16;
  localparam int ASSOC_W = 32;
  localparam int KEY_W   = PORT_W + ASSOC_W;

  // Default table depth
  localparam int MAX_ENTRIES_DEF = 64;

  // Item opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_EXACT  = 2'd2;
  localparam logic [1:0] OP_NEXT   = 2'd3;

  // Key length codes
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_PORT = 2'd1;
  localparam logic [1:0] LEN_PAIR = 2'd2;

  typedef logic [KEY_W-1:0] key_t;

endpackage

>>> rtl/core/tksl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tksl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/two_key_successor_lookup_top.sv
// Top level of the two-key successor lookup: table RAM, scan sequencer, result register.
// Clear and append do not raise busy; the next item may follow at once.
// A query raises busy while the sequencer reads each stored entry in turn; on an empty table or a key that
// cannot match no entry is read. The registered result strobe comes as busy drops.
// Queries do not overlap: start is ignored while busy, and each scan does one RAM read per stored entry.
// Synchronous reset empties the table (count to zero); RAM contents are not cleared.
module two_key_successor_lookup_top
  import tksl_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [PORT_W-1:0]  in_key_port,
  input  logic [ASSOC_W-1:0] in_key_assoc,
  input  logic [1:0]         in_key_len,
  output logic               out_valid,
  output logic               out_found,
  output logic [PORT_W-1:0]  out_match_port,
  output logic [ASSOC_W-1:0] out_match_assoc
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic          have_r, have_nxt;
  logic          exact_r, exact_nxt;
  logic          none_r, none_nxt;
  key_t          start_r, start_nxt;
  key_t          best_r, best_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [PORT_W-1:0]  out_port_r, out_port_nxt;
  logic [ASSOC_W-1:0] out_assoc_r, out_assoc_nxt;

  logic          accept;
  logic [1:0]    len_sat;
  logic [KEY_W:0] pair_inc;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  key_t          ram_rdata;
  logic          issue;
  logic          hit;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Key length saturates at two parts
  assign len_sat  = (in_key_len > LEN_PAIR) ? LEN_PAIR : in_key_len;
  assign pair_inc = {1'b0, in_key_port, in_key_assoc} + {{KEY_W{1'b0}}, 1'b1};

  // Append writes at the fill count; read data is used only while scanning, so no overlap
  assign ram_we    = accept && (in_opcode == OP_APPEND) && (cnt_r < CW'(MAX_ENTRIES));
  assign ram_raddr = idx_r[AW-1:0];

  tksl_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_key_port, in_key_assoc}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan issues one read per stored entry unless the query cannot match
  assign issue = (state_r == ST_SCAN) && !none_r && (idx_r < cnt_r);
  assign hit   = have_r && (!exact_r || (best_r == start_r));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    have_nxt      = have_r;
    exact_nxt     = exact_r;
    none_nxt      = none_r;
    start_nxt     = start_r;
    best_nxt      = best_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_port_nxt  = out_port_r;
    out_assoc_nxt = out_assoc_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            OP_APPEND: begin
              if (ram_we) begin
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            OP_EXACT: begin
              state_nxt = ST_SCAN;
              idx_nxt   = '0;
              have_nxt  = 1'b0;
              exact_nxt = 1'b1;
              start_nxt = {in_key_port, in_key_assoc};
              none_nxt  = (len_sat != LEN_PAIR);
            end
            OP_NEXT: begin
              state_nxt = ST_SCAN;
              idx_nxt   = '0;
              have_nxt  = 1'b0;
              exact_nxt = 1'b0;
              none_nxt  = 1'b0;
              unique case (len_sat)
                LEN_NONE: start_nxt = '0;
                LEN_PORT: start_nxt = {in_key_port, {ASSOC_W{1'b0}}};
                default: begin
                  // Past the largest pair nothing can follow
                  start_nxt = pair_inc[KEY_W-1:0];
                  none_nxt  = pair_inc[KEY_W];
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end
        // Keep the least entry at or above the start point
        if (pend_r && (ram_rdata >= start_r) && (!have_r || (ram_rdata < best_r))) begin
          best_nxt = ram_rdata;
          have_nxt = 1'b1;
        end
        if (!issue && !pend_r) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_found_nxt = hit;
          out_port_nxt  = hit ? best_r[KEY_W-1:ASSOC_W] : '0;
          out_assoc_nxt = hit ? best_r[ASSOC_W-1:0] : '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    have_r      <= have_nxt;
    exact_r     <= exact_nxt;
    none_r      <= none_nxt;
    start_r     <= start_nxt;
    best_r      <= best_nxt;
    out_found_r <= out_found_nxt;
    out_port_r  <= out_port_nxt;
    out_assoc_r <= out_assoc_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_port  = out_port_r;
  assign out_match_assoc = out_assoc_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES))
    else $error("fill count beyond table depth");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still scanning");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_opcode == OP_EXACT) || (in_opcode == OP_NEXT))) |=> busy)
    else $error("query accepted without starting a scan");

  a_table_op_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_opcode == OP_CLEAR) || (in_opcode == OP_APPEND)))
      |=> (!busy && !out_valid))
    else $error("clear or append produced activity");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> ((out_match_port == '0) && (out_match_assoc == '0)))
    else $error("miss result carries nonzero key");

endmodule
